### hw/rtl/hbkrd_pkg.sv
// hbkrd_pkg: shared constants and types for the boot keyboard report differ
// no dependencies
package hbkrd_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int MOD_BITS  = 8;
    localparam int CODE_W    = 8;
    localparam int N_EVENTS  = MOD_BITS + 2 * KEY_SLOTS;
    localparam int IN_DATA_W  = ((MOD_BITS + KEY_SLOTS * CODE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((CODE_W + 1 + 7) / 8) * 8;

    localparam logic [CODE_W-1:0] FIRST_KEY_CODE = CODE_W'(4);
    localparam logic [CODE_W-1:0] EMPTY_CODE     = '0;

    typedef logic [CODE_W-1:0] t_code;

    typedef enum logic {
        KIND_KEY = 1'b0,
        KIND_MOD = 1'b1
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
        t_code code;
        logic  pressed;
    } t_event;

    localparam t_event EVENT_NONE = '{valid: 1'b0, kind: KIND_KEY, code: EMPTY_CODE,
                                      pressed: 1'b0};

endpackage

### hw/rtl/hbkrd_cell.sv
// hbkrd_cell: one stage of the event chain, holds one pending event
// depends on hbkrd_pkg
module hbkrd_cell
    import hbkrd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  logic   i_shift,
    input  t_event i_load_ev,
    input  t_event i_next_ev,
    output t_event o_ev
);

    t_event r_ev;
    t_event n_ev;

    always_comb begin
        n_ev = r_ev;
        if (i_load) begin
            n_ev = i_load_ev;
        end else if (i_shift) begin
            n_ev = i_next_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev.valid <= 1'b0;
        end else begin
            r_ev.valid <= n_ev.valid;
        end
        r_ev.kind    <= n_ev.kind;
        r_ev.code    <= n_ev.code;
        r_ev.pressed <= n_ev.pressed;
    end

    assign o_ev = r_ev;

endmodule

### hw/rtl/hbkrd_diff.sv
// hbkrd_diff: stored previous report and comparison against a new report
// depends on hbkrd_pkg
module hbkrd_diff
    import hbkrd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_report_ok,
    input  logic [MOD_BITS-1:0] i_mods,
    input  t_code               i_keys [KEY_SLOTS],
    output t_event              o_events [N_EVENTS]
);

    logic [MOD_BITS-1:0] r_prev_mods;
    t_code               r_prev_keys [KEY_SLOTS];
    logic [MOD_BITS-1:0] w_delta;
    logic                w_rollover;
    logic                w_update;

    assign w_delta  = i_mods ^ r_prev_mods;
    assign w_update = i_accept && i_report_ok && !w_rollover;

    always_comb begin
        logic found;
        w_rollover = 1'b0;
        for (int i = 0; i < MOD_BITS; i++) begin
            o_events[i].valid   = i_report_ok && w_delta[i];
            o_events[i].kind    = KIND_MOD;
            o_events[i].code    = CODE_W'(i);
            o_events[i].pressed = i_mods[i];
        end
        // releases: old codes missing from the new report
        for (int i = 0; i < KEY_SLOTS; i++) begin
            found = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                found = found | (i_keys[j] == r_prev_keys[i]);
            end
            o_events[MOD_BITS + i].valid   = i_report_ok && !found
                                             && (r_prev_keys[i] != EMPTY_CODE);
            o_events[MOD_BITS + i].kind    = KIND_KEY;
            o_events[MOD_BITS + i].code    = r_prev_keys[i];
            o_events[MOD_BITS + i].pressed = 1'b0;
        end
        // presses: new usage codes (FIRST_KEY_CODE and up) missing from the old report
        for (int i = 0; i < KEY_SLOTS; i++) begin
            found = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                found = found | (r_prev_keys[j] == i_keys[i]);
            end
            o_events[MOD_BITS + KEY_SLOTS + i].valid   = i_report_ok && !found
                                                         && (i_keys[i] >= FIRST_KEY_CODE);
            o_events[MOD_BITS + KEY_SLOTS + i].kind    = KIND_KEY;
            o_events[MOD_BITS + KEY_SLOTS + i].code    = i_keys[i];
            o_events[MOD_BITS + KEY_SLOTS + i].pressed = 1'b1;
            if ((i_keys[i] != EMPTY_CODE) && (i_keys[i] < FIRST_KEY_CODE)) begin
                w_rollover = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mods <= '0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_prev_keys[i] <= EMPTY_CODE;
            end
        end else if (w_update) begin
            r_prev_mods <= i_mods;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_prev_keys[i] <= i_keys[i];
            end
        end
    end

endmodule

### hw/rtl/hid_boot_keyboard_report_differ.sv
// hid_boot_keyboard_report_differ: top level, report in, key events out
// depends on hbkrd_pkg, hbkrd_diff, hbkrd_cell
//
// Each accepted boot keyboard report is compared with the stored previous
// report and all of its events (modifier changes bit 0 to 7, then releases
// in old slot order, then presses in new slot order) are loaded at once into
// a chain of 20 cells, one cell per possible event. The chain moves one cell
// per cycle toward an output register whenever its head cell is empty or the
// output register can take the head event. The input therefore stays busy
// until the report's last event has left the chain, and longer while the
// output side stalls. A report with no events keeps the input ready. A new
// report is accepted as soon as the chain holds no pending event, while the
// last event may still wait in the output register. tlast marks the final
// event of a report. A report with a rollover code (1 to 3) still gives its
// events but leaves the stored report unchanged; a report with tuser low
// gives no events.
module hid_boot_keyboard_report_differ
    import hbkrd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // modifiers, key_slot0 .. key_slot5
    input  logic                  s_axis_tuser,  // report_ok
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // event_code, is_pressed, zero fill
    output logic                  m_axis_tuser,  // event_kind
    output logic                  m_axis_tlast   // last_event
);

    logic                w_accept;
    logic                w_advance;
    logic                w_out_ready;
    logic [MOD_BITS-1:0] w_mods;
    t_code               w_keys [KEY_SLOTS];
    t_event              w_events [N_EVENTS];
    t_event              w_cell [N_EVENTS];
    t_event              w_next [N_EVENTS];
    logic [N_EVENTS-1:0] w_pending;

    logic                r_out_valid;
    t_kind               r_out_kind;
    t_code               r_out_code;
    logic                r_out_pressed;
    logic                r_out_last;

    assign w_mods = s_axis_tdata[MOD_BITS-1:0];

    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            w_keys[i] = s_axis_tdata[MOD_BITS + CODE_W * i +: CODE_W];
        end
    end

    assign s_axis_tready = ~|w_pending;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign w_advance     = !w_cell[0].valid || w_out_ready;

    hbkrd_diff u_diff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_report_ok (s_axis_tuser),
        .i_mods      (w_mods),
        .i_keys      (w_keys),
        .o_events    (w_events)
    );

    for (genvar g = 0; g < N_EVENTS; g++) begin : g_chain
        if (g == N_EVENTS - 1) begin : g_tail
            assign w_next[g] = EVENT_NONE;
        end else begin : g_body
            assign w_next[g] = w_cell[g + 1];
        end

        assign w_pending[g] = w_cell[g].valid;

        hbkrd_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (w_accept),
            .i_shift   (w_advance),
            .i_load_ev (w_events[g]),
            .i_next_ev (w_next[g]),
            .o_ev      (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_cell[0].valid;
        end
        if (w_out_ready) begin
            r_out_kind    <= w_cell[0].kind;
            r_out_code    <= w_cell[0].code;
            r_out_pressed <= w_cell[0].pressed;
            r_out_last    <= ~|w_pending[N_EVENTS-1:1];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - CODE_W - 1){1'b0}}, r_out_pressed, r_out_code};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

### hw/rtl/hbkrd_checker.sv
// hbkrd_checker: port-level checks on the report differ, bound to the top level
// depends on hbkrd_pkg, hid_boot_keyboard_report_differ
module hbkrd_checker
    import hbkrd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  m_axis_tlast
);

    // stalled transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // modifier events carry a bit index
    a_mod_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_MOD) |-> m_axis_tdata[CODE_W-1:3] == '0)
        else $error("modifier index out of range");

    // released keys are never the empty code
    a_release_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_KEY) && !m_axis_tdata[CODE_W] |->
            m_axis_tdata[CODE_W-1:0] != EMPTY_CODE)
        else $error("release of empty code");

    // pressed keys are real usage codes
    a_press_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_KEY) && m_axis_tdata[CODE_W] |->
            m_axis_tdata[CODE_W-1:0] >= FIRST_KEY_CODE)
        else $error("press of reserved code");

endmodule

bind hid_boot_keyboard_report_differ hbkrd_checker u_hbkrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking stream test of hid_boot_keyboard_report_differ
// depends on hbkrd_pkg and the hid_boot_keyboard_report_differ rtl
module testbench;
    import hbkrd_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 400;

    typedef struct {
        logic       ok;
        logic [7:0] mods;
        t_code      keys[KEY_SLOTS];
    } t_report;

    typedef struct {
        t_kind kind;
        t_code code;
        logic  pressed;
        logic  last;
    } t_key_event;

    class key_event_scoreboard;
        logic [7:0] prev_mods;
        t_code      prev_keys[KEY_SLOTS];
        t_key_event expected_events[$];
        int         n_reports;
        int         n_rollovers;
        int         n_events;
        int         n_errors;

        function new();
            prev_mods = '0;
            foreach (prev_keys[i]) prev_keys[i] = EMPTY_CODE;
            n_reports   = 0;
            n_rollovers = 0;
            n_events    = 0;
            n_errors    = 0;
        endfunction

        function void note_report(t_report rep);
            t_key_event ev;
            t_key_event found[$];
            logic       rollover;
            logic       hit;
            rollover = 1'b0;
            if (!rep.ok) return;
            n_reports++;
            for (int b = 0; b < MOD_BITS; b++) begin
                if (rep.mods[b] != prev_mods[b]) begin
                    ev.kind = KIND_MOD;
                    ev.code = t_code'(b);
                    ev.pressed = rep.mods[b];
                    ev.last = 1'b0;
                    found.push_back(ev);
                end
            end
            for (int s = 0; s < KEY_SLOTS; s++) begin
                hit = 1'b0;
                foreach (rep.keys[j]) if (rep.keys[j] == prev_keys[s]) hit = 1'b1;
                if (prev_keys[s] != EMPTY_CODE && !hit) begin
                    ev.kind = KIND_KEY;
                    ev.code = prev_keys[s];
                    ev.pressed = 1'b0;
                    ev.last = 1'b0;
                    found.push_back(ev);
                end
            end
            for (int s = 0; s < KEY_SLOTS; s++) begin
                if (rep.keys[s] >= FIRST_KEY_CODE) begin
                    hit = 1'b0;
                    foreach (prev_keys[j]) if (prev_keys[j] == rep.keys[s]) hit = 1'b1;
                    if (!hit) begin
                        ev.kind = KIND_KEY;
                        ev.code = rep.keys[s];
                        ev.pressed = 1'b1;
                        ev.last = 1'b0;
                        found.push_back(ev);
                    end
                end else if (rep.keys[s] != EMPTY_CODE) begin
                    rollover = 1'b1;
                end
            end
            if (rollover) begin
                n_rollovers++;
            end else begin
                prev_mods = rep.mods;
                foreach (prev_keys[i]) prev_keys[i] = rep.keys[i];
            end
            if (found.size() > 0) found[found.size()-1].last = 1'b1;
            foreach (found[i]) expected_events.push_back(found[i]);
        endfunction

        function void check_event(t_key_event got);
            t_key_event want;
            if (expected_events.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected event, expected none, got kind=%0d code=%0d",
                         $time, got.kind, got.code);
                $display("%0t: unexpected event, got pressed=%0d last=%0d",
                         $time, got.pressed, got.last);
                return;
            end
            want = expected_events.pop_front();
            n_events++;
            if (got.kind != want.kind) begin
                n_errors++;
                $display("%0t: event kind mismatch, expected %0d, got %0d", $time, want.kind,
                         got.kind);
            end
            if (got.code != want.code) begin
                n_errors++;
                $display("%0t: event code mismatch, expected %0d, got %0d", $time, want.code,
                         got.code);
            end
            if (got.pressed !== want.pressed) begin
                n_errors++;
                $display("%0t: pressed flag mismatch, expected %0d, got %0d", $time,
                         want.pressed, got.pressed);
            end
            if (got.last !== want.last) begin
                n_errors++;
                $display("%0t: last flag mismatch, expected %0d, got %0d", $time, want.last,
                         got.last);
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // modifiers, key_slot0 .. key_slot5
    logic                  s_axis_tuser = 1'b0; // report_ok
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // event_code, is_pressed, zero fill
    logic                  m_axis_tuser;        // event_kind
    logic                  m_axis_tlast;        // last_event

    key_event_scoreboard board = new();

    logic tx_idle_en = 1'b1;
    logic rx_idle_en = 1'b1;
    logic rx_hold_armed = 1'b0;
    logic rx_hold_taken = 1'b0;
    int   rx_hold_left = 0;
    int   cycle_cnt = 0;

    hid_boot_keyboard_report_differ u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // transfer monitor on both sides
    always @(posedge i_clk) begin
        t_report    rep;
        t_key_event got;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            rep.ok = s_axis_tuser;
            rep.mods = s_axis_tdata[MOD_BITS-1:0];
            foreach (rep.keys[i]) rep.keys[i] = s_axis_tdata[MOD_BITS + i*CODE_W +: CODE_W];
            board.note_report(rep);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = t_kind'(m_axis_tuser);
            got.code = m_axis_tdata[CODE_W-1:0];
            got.pressed = m_axis_tdata[CODE_W];
            got.last = m_axis_tlast;
            board.check_event(got);
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_armed && !rx_hold_taken) begin
            m_axis_tready <= 1'b0;
            rx_hold_taken <= 1'b1;
            rx_hold_left <= HOLD_CYCLES;
        end else if (rx_idle_en) begin
            m_axis_tready <= ($urandom_range(99) >= 31);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("hid_boot_keyboard_report_differ test failed");
            $finish;
        end
    end

    task automatic offer_report(input t_report rep);
        logic [IN_DATA_W-1:0] data;
        data = '0;
        data[MOD_BITS-1:0] = rep.mods;
        foreach (rep.keys[i]) data[MOD_BITS + i*CODE_W +: CODE_W] = rep.keys[i];
        if (tx_idle_en) begin
            while ($urandom_range(99) < 31) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= rep.ok;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_keys(input logic ok, input logic [7:0] mods, input t_code k0,
                             input t_code k1, input t_code k2, input t_code k3,
                             input t_code k4, input t_code k5);
        t_report rep;
        rep.ok = ok;
        rep.mods = mods;
        rep.keys[0] = k0;
        rep.keys[1] = k1;
        rep.keys[2] = k2;
        rep.keys[3] = k3;
        rep.keys[4] = k4;
        rep.keys[5] = k5;
        offer_report(rep);
    endtask

    function automatic t_code pick_key();
        if ($urandom_range(3) == 0) return t_code'($urandom_range(12, 4));
        return t_code'($urandom_range(255, 4));
    endfunction

    initial begin
        t_report held;
        t_report rep;
        int      sent;
        int      pick;
        int      slot;
        int      other;
        t_code   tmp;
        logic    bad;

        held.ok = 1'b1;
        held.mods = '0;
        foreach (held.keys[i]) held.keys[i] = EMPTY_CODE;
        sent = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed reports
        send_keys(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_keys(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_keys(1'b1, 8'hFF, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9);
        send_keys(1'b1, 8'h00, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15);
        send_keys(1'b1, 8'h00, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15);
        send_keys(1'b1, 8'hA5, 8'hFF, 8'h80, 8'h7F, 8'd1, 8'd0, 8'd0);
        send_keys(1'b1, 8'h5A, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        send_keys(1'b1, 8'h00, 8'd20, 8'd20, 8'd20, 8'd0, 8'd0, 8'd0);
        send_keys(1'b1, 8'h00, 8'd20, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_keys(1'b1, 8'h00, 8'd0, 8'd20, 8'd2, 8'd0, 8'd0, 8'd0);
        send_keys(1'b1, 8'h01, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd3);
        send_keys(1'b1, 8'h80, 8'd4, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0);
        send_keys(1'b0, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_keys(1'b1, 8'h80, 8'd255, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0);
        send_keys(1'b1, 8'h7F, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_keys(1'b1, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

        // random reports, mostly plausible key changes
        while (sent < RANDOM_ITEMS) begin
            if (sent == 100 && !rx_hold_armed) begin
                rx_hold_armed = 1'b1;
                tx_idle_en = 1'b0;
            end
            if (sent == 130) tx_idle_en = 1'b1;
            if (sent == 200) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (board.pending() > 0) @(posedge i_clk);
            end
            if (sent == 250) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            if (sent == 330) begin
                tx_idle_en = 1'b1;
                rx_idle_en = 1'b1;
            end

            rep = held;
            rep.ok = 1'b1;
            pick = $urandom_range(99);
            if (pick < 10) begin
                rep.ok = 1'b0;
                rep.mods = 8'($urandom());
                foreach (rep.keys[i]) rep.keys[i] = t_code'($urandom());
            end else if (pick < 18) begin
                rep.mods = 8'($urandom());
                foreach (rep.keys[i]) rep.keys[i] = t_code'($urandom());
            end else if (pick < 24) begin
                if ($urandom_range(1)) begin
                    foreach (rep.keys[i]) rep.keys[i] = t_code'($urandom_range(3, 1));
                end else begin
                    rep.keys[$urandom_range(KEY_SLOTS-1)] = t_code'($urandom_range(3, 1));
                end
                if ($urandom_range(1)) rep.mods = rep.mods ^ 8'(1 << $urandom_range(7));
            end else if (pick < 28) begin
                // same report again
            end else begin
                if ($urandom_range(2) == 0) rep.mods = rep.mods ^ 8'($urandom());
                repeat ($urandom_range(3, 1)) begin
                    slot = $urandom_range(KEY_SLOTS-1);
                    if ($urandom_range(5) == 0) begin
                        other = $urandom_range(KEY_SLOTS-1);
                        tmp = rep.keys[slot];
                        rep.keys[slot] = rep.keys[other];
                        rep.keys[other] = tmp;
                    end else if (rep.keys[slot] == EMPTY_CODE) begin
                        rep.keys[slot] = pick_key();
                    end else if ($urandom_range(3) == 0) begin
                        rep.keys[slot] = pick_key();
                    end else begin
                        rep.keys[slot] = EMPTY_CODE;
                    end
                end
            end

            offer_report(rep);
            sent++;
            if (rep.ok) begin
                bad = 1'b0;
                foreach (rep.keys[i]) begin
                    if (rep.keys[i] != EMPTY_CODE && rep.keys[i] < FIRST_KEY_CODE) bad = 1'b1;
                end
                if (!bad) held = rep;
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        while (board.pending() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d accepted reports (%0d with rollover codes), %0d events checked",
                 board.n_reports, board.n_rollovers, board.n_events);
        $display("with random stalls, a long output hold-off and a drain pause");
        if (board.n_errors == 0 && board.pending() == 0) begin
            $display("hid_boot_keyboard_report_differ test passed");
        end else begin
            $display("%0d errors, %0d events still expected", board.n_errors, board.pending());
            $display("hid_boot_keyboard_report_differ test failed");
        end
        $finish;
    end

endmodule
